### hdl/ptln_pkg.sv
package ptln_pkg;

    localparam int CHANNELS_DEF    = 6;
    localparam int SAMPLE_BITS_DEF = 32;

    localparam int CH_W      = 3;
    localparam int OUT_W     = 19;
    localparam int FRAC_BITS = 16;
    localparam int Y_W       = 31;
    localparam int ONE_Q16   = 65536;

endpackage

### hdl/ptln_log2.sv
module ptln_log2 #(
    parameter int VW = 34,
    parameter int LW = 21
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [VW-1:0] i_value,
    output logic          o_done,
    output logic [LW-1:0] o_result
);

    localparam int W  = (VW > ptln_pkg::Y_W) ? VW : ptln_pkg::Y_W;
    localparam int SW = $clog2(W);
    localparam int IW = LW - ptln_pkg::FRAC_BITS;
    localparam int FB = ptln_pkg::FRAC_BITS;
    localparam int YW = ptln_pkg::Y_W;

    typedef enum logic [1:0] {S_IDLE, S_NORM, S_SQR} t_state;

    t_state                r_state;
    logic [W-1:0]          r_sh;
    logic [SW-1:0]         r_cnt;
    logic [YW-1:0]         r_y;
    logic [FB-1:0]         r_frac;
    logic [3:0]            r_step;
    logic [IW-1:0]         r_int;
    logic                  r_done;

    logic [2*YW-1:0]       prod;
    logic [YW:0]           sq;

    assign prod     = (2*YW)'(r_y) * (2*YW)'(r_y);
    assign sq       = prod[2*YW-1 -: YW+1];
    assign o_done   = r_done;
    assign o_result = {r_int, r_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_sh    <= W'(i_value);
                        r_cnt   <= '0;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    // shift until the leading one reaches the top
                    if (r_sh[W-1]) begin
                        r_y     <= r_sh[W-1 -: YW];
                        r_int   <= IW'(SW'(W - 1 - FB) - r_cnt);
                        r_frac  <= '0;
                        r_step  <= '0;
                        r_state <= S_SQR;
                    end else begin
                        r_sh  <= r_sh << 1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SQR: begin
                    r_frac <= {r_frac[FB-2:0], sq[YW]};
                    r_y    <= sq[YW] ? sq[YW:1] : sq[YW-1:0];
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'(FB - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### hdl/ptln_div.sv
module ptln_div #(
    parameter int NW = 37,
    parameter int DW = 21
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient
);

    localparam int CNW = $clog2(NW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [DW:0]    r_rem;
    logic [NW-1:0]  r_q;
    logic [DW-1:0]  r_den;

    logic [DW:0]    trial;
    logic [DW:0]    diff;
    logic           ge;

    assign trial      = {r_rem[DW-1:0], r_q[NW-1]};
    assign ge         = trial >= {1'b0, r_den};
    assign diff       = trial - {1'b0, r_den};
    assign o_done     = r_done;
    assign o_quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                // one quotient bit per cycle, shifted in behind the dividend
                r_rem <= ge ? diff : trial;
                r_q   <= {r_q[NW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

### hdl/peak_tracking_log_normalizer_unit.sv
// Peak-tracking log normalizer. Each transaction carries a signed Q16.16 sample
// for one channel; the channel's peak magnitude is tracked (clear_peaks first
// returns all peaks to 1.0) and the result is ln(min(|s|,M)+1)/ln(M) with the
// sample's sign, M being the integer part of the peak. Small peaks, zero samples
// and out-of-range channels skip the log and divide steps: their result goes
// from acceptance straight to S_OUT and then into the output register. Otherwise
// one shared log2 unit runs twice (leading-one search one bit per cycle, then 16
// squaring steps) and a restoring divider produces one quotient bit per cycle.
// At the default 32-bit sample width the log operand is 33 bits wide and the log
// result 21 bits. The leading-one search is shortest for large operands, so big
// samples run faster. One item is in work at a time; a finished result waits in
// the output register while the next item is accepted.
module peak_tracking_log_normalizer_unit #(
    parameter int CHANNELS    = ptln_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = ptln_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [ptln_pkg::CH_W-1:0]             i_channel,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    input  logic                                  i_clear_peaks,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [ptln_pkg::CH_W-1:0]             o_channel_out,
    output logic signed [ptln_pkg::OUT_W-1:0]     o_normalized
);

    localparam int SB  = SAMPLE_BITS;
    localparam int FB  = ptln_pkg::FRAC_BITS;
    localparam int OW  = ptln_pkg::OUT_W;
    localparam int PW  = (SB > FB + 1) ? SB : FB + 1;
    localparam int VW  = PW + 1;
    localparam int LGW = (VW > ptln_pkg::Y_W) ? VW : ptln_pkg::Y_W;
    localparam int LW  = FB + $clog2(LGW - FB);
    localparam int NW  = LW + FB;
    localparam int RW  = (SB > OW) ? SB : OW;
    localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {S_IDLE, S_NUM, S_DEN, S_DIV, S_OUT} t_state;

    t_state                r_state;
    logic [PW-1:0]         r_peak [CHANNELS];
    logic [ptln_pkg::CH_W-1:0] r_ch;
    logic                  r_neg;
    logic [PW-1:0]         r_lim;
    logic [VW-1:0]         r_opnd;
    logic [LW-1:0]         r_num;
    logic [LW-1:0]         r_den;
    logic [OW-1:0]         r_res;
    logic                  r_log_go;
    logic                  r_div_go;
    logic                  r_out_valid;
    logic [ptln_pkg::CH_W-1:0] r_out_ch;
    logic [OW-1:0]         r_out_norm;

    logic [SB-1:0]         s_raw;
    logic                  s_neg;
    logic [SB:0]           s_mag_w;
    logic [PW-1:0]         s_mag;
    logic [PW-1:0]         s_cur;
    logic [PW-1:0]         s_newpk;
    logic [PW-1:0]         s_lim;
    logic [PW-1:0]         s_clamp;
    logic [VW-1:0]         s_v;
    logic [CW-1:0]         s_idx;
    logic                  s_in_range;
    logic                  s_small;
    logic [OW-1:0]         s_raw_out;
    logic                  s_accept;

    logic                  log_done;
    logic [LW-1:0]         log_res;
    logic                  div_done;
    logic [NW-1:0]         div_q;
    logic [OW-1:0]         q_out;

    assign s_accept   = i_valid && !o_stall;
    assign s_raw      = $unsigned(i_sample);
    assign s_neg      = s_raw[SB-1];
    assign s_mag_w    = s_neg ? (((SB+1)'(1) << SB) - {1'b0, s_raw}) : {1'b0, s_raw};
    assign s_mag      = PW'(s_mag_w);
    assign s_idx      = CW'(i_channel);
    assign s_in_range = 32'(i_channel) < CHANNELS;
    assign s_cur      = i_clear_peaks ? PW'(ptln_pkg::ONE_Q16) : r_peak[s_idx];
    assign s_newpk    = (s_mag > s_cur) ? s_mag : s_cur;
    assign s_lim      = (s_newpk >> FB) << FB;
    assign s_small    = (s_newpk >> (FB + 1)) == '0;
    assign s_clamp    = (s_mag > s_lim) ? s_lim : s_mag;
    assign s_v        = VW'(s_clamp) + VW'(ptln_pkg::ONE_Q16);
    assign s_raw_out  = OW'(RW'(s_raw));
    assign q_out      = div_q[OW-1:0];

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_channel_out = r_out_ch;
    assign o_normalized  = $signed(r_out_norm);

    ptln_log2 #(
        .VW (VW),
        .LW (LW)
    ) u_log2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_log_go),
        .i_value  (r_opnd),
        .o_done   (log_done),
        .o_result (log_res)
    );

    ptln_div #(
        .NW (NW),
        .DW (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend ({r_num, FB'(0)}),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_log_go    <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_peak[i] <= PW'(ptln_pkg::ONE_Q16);
            end
        end else begin
            r_log_go <= 1'b0;
            r_div_go <= 1'b0;
            if (r_out_valid && !i_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        // the addressed channel takes its new peak; with clear_peaks the rest clear
                        for (int i = 0; i < CHANNELS; i++) begin
                            if (s_in_range && (CW'(i) == s_idx)) begin
                                r_peak[i] <= s_newpk;
                            end else if (i_clear_peaks) begin
                                r_peak[i] <= PW'(ptln_pkg::ONE_Q16);
                            end
                        end
                        r_ch  <= i_channel;
                        r_neg <= s_neg;
                        r_lim <= s_lim;
                        if (!s_in_range) begin
                            r_res   <= '0;
                            r_state <= S_OUT;
                        end else if (s_small || (s_raw == '0)) begin
                            r_res   <= s_raw_out;
                            r_state <= S_OUT;
                        end else begin
                            r_opnd   <= s_v;
                            r_log_go <= 1'b1;
                            r_state  <= S_NUM;
                        end
                    end
                end
                S_NUM: begin
                    if (log_done) begin
                        r_num    <= log_res;
                        r_opnd   <= VW'(r_lim);
                        r_log_go <= 1'b1;
                        r_state  <= S_DEN;
                    end
                end
                S_DEN: begin
                    if (log_done) begin
                        r_den    <= log_res;
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_res   <= r_neg ? (OW'(0) - q_out) : q_out;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_ch    <= r_ch;
                        r_out_norm  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

class norm_scoreboard;
    bit [2:0]   exp_channel[$];
    bit [18:0]  exp_norm[$];
    bit [31:0]  peak[6];
    int         mismatches;

    function new();
        mismatches = 0;
        for (int i = 0; i < 6; i++) peak[i] = 32'd65536;
    endfunction

    function bit [63:0] log2_fix(bit [63:0] v);
        int p;
        bit [63:0] y;
        bit [63:0] frac;
        p = 63;
        frac = 0;
        while (v[p] == 1'b0) p--;
        if (p >= 30) y = v >> (p - 30);
        else y = v << (30 - p);
        for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= 64'h8000_0000) begin
                y = y >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(p - 16) << 16) | frac;
    endfunction

    function void note_input(bit [2:0] ch, bit [31:0] raw, bit clr);
        bit neg;
        bit [63:0] mag, m, lim, a, num, den, q, res;
        neg = raw[31];
        mag = neg ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
        res = 0;
        if (clr) for (int i = 0; i < 6; i++) peak[i] = 32'd65536;
        if (ch < 6) begin
            if (mag > {32'd0, peak[ch]}) peak[ch] = mag[31:0];
            m = {32'd0, peak[ch]} >> 16;
            if (m <= 1 || raw == 0) begin
                res = {32'd0, raw};
            end else begin
                lim = m << 16;
                a = (mag > lim) ? lim : mag;
                num = log2_fix(a + 64'd65536);
                den = log2_fix(lim);
                q = (num << 16) / den;
                res = neg ? (64'd0 - q) : q;
            end
        end
        exp_channel.push_back(ch);
        exp_norm.push_back(res[18:0]);
    endfunction

    function bit check_result(bit [2:0] ch, bit [18:0] norm);
        bit [2:0] ec;
        bit [18:0] en;
        if (exp_channel.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result ch=%0d norm=%h", ch, norm);
            return 0;
        end
        ec = exp_channel.pop_front();
        en = exp_norm.pop_front();
        if (ec !== ch || en !== norm) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected ch=%0d norm=%h, got ch=%0d norm=%h",
                         ec, en, ch, norm);
            return 0;
        end
        return 1;
    endfunction

    function int pending();
        return exp_channel.size();
    endfunction
endclass

module testbench;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [ptln_pkg::CH_W-1:0]    i_channel;
    logic signed [31:0] i_sample;
    logic               i_clear_peaks;
    logic               o_valid;
    logic               i_stall;
    logic [ptln_pkg::CH_W-1:0]    o_channel_out;
    logic signed [ptln_pkg::OUT_W-1:0] o_normalized;

    norm_scoreboard sb;
    int  cycles;
    bit  hold_off_long;
    bit  sending_done;

    peak_tracking_log_normalizer_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Apply one transaction and wait until it is taken.
    task automatic send_item(bit [2:0] ch, bit [31:0] s, bit clr);
        i_valid       <= 1'b1;
        i_channel     <= ch;
        i_sample      <= s;
        i_clear_peaks <= clr;
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_input(ch, s, clr);
        @(negedge i_clk);
    endtask

    task automatic send_gap(int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic bit [31:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return $urandom_range(0, 131071);
            2: return -$urandom_range(0, 131071);
            3: return $urandom_range(0, 32'h00FF_FFFF);
            4: return -$urandom_range(0, 32'h00FF_FFFF);
            5: return 32'h8000_0000 | $urandom_range(0, 3);
            6: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 32'h0FFF_FFFF) << $urandom_range(0, 3);
        endcase
    endfunction

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        bit [31:0] directed[12];
        sb = new();
        hold_off_long = 0;
        sending_done = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_channel = '0;
        i_sample = '0;
        i_clear_peaks = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        directed = '{32'h0, 32'h0000_8000, 32'hFFFF_8000, 32'h0001_FFFF, 32'h0002_0000,
                     32'hFFFE_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                     32'hFFFF_FFFF, 32'h0010_0000, 32'h0003_0000};
        for (int i = 0; i < 12; i++) send_item(3'(i % 6), directed[i], 1'b0);
        // out-of-range channels, with and without clear
        send_item(3'd6, 32'h0005_0000, 1'b0);
        send_item(3'd7, 32'h8000_0000, 1'b1);
        send_item(3'd0, 32'h0000_C000, 1'b0);
        send_item(3'd1, 32'h0004_0000, 1'b1);
        send_item(3'd1, 32'hFFFF_0000, 1'b0);
        send_item(3'd2, 32'h8000_0000, 1'b0);
        wait_drained();
        for (int n = 0; n < 1900; n++) begin
            if (n == 600) begin
                hold_off_long = 1;
            end
            if (n == 1200) begin
                // pause until the block has emptied
                wait_drained();
            end
            if (n < 600 || n > 700) send_gap($urandom_range(0, 18));
            send_item(3'($urandom_range(0, 15) == 0 ? $urandom_range(6, 7)
                                                     : $urandom_range(0, 5)),
                      rand_sample(), $urandom_range(0, 40) == 0);
        end
        i_valid <= 1'b0;
        sending_done = 1;
    end

    initial begin
        int wait_cycles;
        bit stretch_done;
        i_stall = 1'b0;
        stretch_done = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_long && !stretch_done) begin
                stretch_done = 1;
                i_stall <= 1'b1;
                repeat (3000) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (o_valid) begin
                wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                if (wait_cycles > 0) begin
                    i_stall <= 1'b1;
                    repeat (wait_cycles) @(negedge i_clk);
                end
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            void'(sb.check_result(o_channel_out, o_normalized));
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 2000000) begin
                $display("peak_tracking_log_normalizer_unit regression: fail");
                $finish;
            end
            if (sending_done && sb.pending() == 0) begin
                repeat (200) @(posedge i_clk);
                if (sb.mismatches == 0)
                    $display("peak_tracking_log_normalizer_unit regression: pass");
                else
                    $display("peak_tracking_log_normalizer_unit regression: fail");
                $finish;
            end
        end
    end
endmodule
